/* hw/rtl/hsd_pkg.sv */
// ----------------------------------------------------------------------------
// hsd_pkg: shared types and constants of the Huffman symbol decoder
// Item and result structs, opcodes, controller states, control/status groups
// and the table entry layouts.
// ----------------------------------------------------------------------------
package hsd_pkg;

  localparam int SYMBOL_COUNT    = 256;
  localparam int MAX_CHAIN_STEPS = 256;
  localparam int STEP_W          = $clog2(MAX_CHAIN_STEPS);

  localparam int LOOKUP_DEPTH = 512;
  localparam int LOOKUP_WIDTH = 32;
  localparam int SYMBOL_DEPTH = 512;
  localparam int SYMBOL_WIDTH = 42;

  localparam logic [3:0] SHORT_LEN_MAX = 4'd8;
  localparam logic [7:0] DIST_SYM_LIMIT = 8'd240;
  localparam logic [7:0] DIST_SYM_DIRECT = 8'd16;

  typedef enum logic [2:0] {
    OP_WR_LOOKUP = 3'd0,
    OP_WR_SYMBOL = 3'd1,
    OP_LIT       = 3'd2,
    OP_PAIR      = 3'd3,
    OP_DIST      = 3'd4
  } hsd_opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CHAIN,
    ST_FINISH
  } hsd_state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        table_sel;
    logic [7:0]  entry_index;
    logic [31:0] lookup_word;
    logic [14:0] code_bits;
    logic [14:0] code_mask;
    logic [3:0]  code_len;
    logic [7:0]  chain_link;
    logic [63:0] stream_bits;
  } hsd_in_t;

  typedef struct packed {
    logic [7:0]  first_symbol;
    logic [7:0]  second_symbol;
    logic [1:0]  symbol_count;
    logic [31:0] distance_value;
    logic [5:0]  bits_used;
    logic        error;
  } hsd_out_t;

  // first-level lookup entry
  typedef struct packed {
    logic [3:0] pair_len;
    logic [3:0] code_len;
    logic [5:0] rsv_hi;
    logic [8:0] pair_sym;
    logic       rsv_lo;
    logic [7:0] sym;
  } hsd_lk_entry_t;

  // per-symbol chain entry
  typedef struct packed {
    logic [7:0]  link;
    logic [3:0]  len;
    logic [14:0] mask;
    logic [14:0] code;
  } hsd_sym_entry_t;

  typedef struct packed {
    logic lk_wr;
    logic sy_wr;
    logic lk_rd;
    logic take_short;
    logic chain_first;
    logic chain_next;
    logic take_chain;
    logic set_fail;
    logic finish;
  } hsd_cmd_t;

  typedef struct packed {
    logic is_wr_lookup;
    logic is_wr_symbol;
    logic is_decode;
    logic short_path;
    logic match;
    logic steps_last;
  } hsd_status_t;

  function automatic logic sym_in_range(input logic [7:0] s);
    return {1'b0, s} < 9'(SYMBOL_COUNT);
  endfunction

endpackage

/* hw/rtl/huffman_symbol_decoder.sv */
// ----------------------------------------------------------------------------
// huffman_symbol_decoder: two-table Huffman literal/distance decoder
// Table writes and literal, literal-pair and distance decodes over an
// aligned stream window supplied by the caller.
// ----------------------------------------------------------------------------
//
//  channel   | signals              | transfer
//  ----------+----------------------+-----------------------------------
//  item in   | start, busy, item    | edge with start high and busy low
//  result    | done, result         | edge ending the cycle done is high
//
//  Table writes transfer and leave busy low; they return nothing.
//  A decode holds busy through the lookup read and the format step on the short
//  path, so no new item is taken until it is finished; a long code adds chain
//  compare steps, each one a symbol memory read, up to MAX_CHAIN_STEPS.
//  The result strobes in the first cycle with busy low again; the receiver
//  cannot stall.
//  Reset clears control only; table contents are undefined until written.
//  Unused opcodes are taken and dropped.
// ----------------------------------------------------------------------------
module huffman_symbol_decoder import hsd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  hsd_in_t  item,
  output logic     done,
  output hsd_out_t result
);

  hsd_cmd_t    cmd;
  hsd_status_t status;

  // sequencer: decides each step from datapath status
  hsd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // tables, chain walk and result register
  hsd_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .done   (done),
    .result (result)
  );

`ifndef SYNTH
  // a formatting step always lands on the result strobe
  a_finish_done: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> done)
    else $error("result strobe missing after finish");

  // results only appear once the sequencer is back to taking items
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // an accepted decode must occupy the block
  a_decode_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.opcode == OP_LIT || item.opcode == OP_PAIR ||
     item.opcode == OP_DIST)) |=> busy)
    else $error("decode accepted without going busy");

  // table writes only happen on an accepted item
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.lk_wr || cmd.sy_wr) |-> (start && !busy))
    else $error("table write outside an accepted item");
`endif

endmodule

/* hw/rtl/hsd_ram.sv */
// ----------------------------------------------------------------------------
// hsd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/hsd_datapath.sv */
// ----------------------------------------------------------------------------
// hsd_datapath: tables, chain walk registers and result formatting
// Holds both lookup and symbol memories, the captured window, the chain
// cursor and step count, and the result register.
// ----------------------------------------------------------------------------
module hsd_datapath import hsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  hsd_in_t     item,
  input  hsd_cmd_t    cmd,
  output hsd_status_t status,
  output logic        done,
  output hsd_out_t    result
);

  logic [2:0]        op;
  logic [63:0]       win;
  hsd_lk_entry_t     entry;
  logic [7:0]        sym;
  logic [3:0]        len;
  logic              short_path;
  logic              fail;
  logic [7:0]        cur_sym;
  logic              cur_oob;
  logic [STEP_W-1:0] step_cnt;

  logic [LOOKUP_WIDTH-1:0] lk_rdata;
  logic [SYMBOL_WIDTH-1:0] sy_rdata;
  hsd_lk_entry_t           lk_q;
  hsd_sym_entry_t          sy_e;
  hsd_sym_entry_t          sy_wdata;
  logic [7:0]              sym_addr_next;
  hsd_out_t                result_next;

  assign lk_q = hsd_lk_entry_t'(lk_rdata);
  // a symbol beyond the table reads as an all-zero entry
  assign sy_e = cur_oob ? '0 : hsd_sym_entry_t'(sy_rdata);

  assign sy_wdata = '{link: item.chain_link, len: item.code_len,
                      mask: item.code_mask, code: item.code_bits};

  assign sym_addr_next = cmd.chain_first ? lk_q.sym : sy_e.link;

  hsd_ram #(.WIDTH(LOOKUP_WIDTH), .DEPTH(LOOKUP_DEPTH)) u_lookup_ram (
    .clk   (clk),
    .we    (cmd.lk_wr),
    .waddr ({item.table_sel, item.entry_index}),
    .wdata (item.lookup_word),
    .re    (cmd.lk_rd),
    .raddr ({item.opcode == OP_DIST, item.stream_bits[7:0]}),
    .rdata (lk_rdata)
  );

  hsd_ram #(.WIDTH(SYMBOL_WIDTH), .DEPTH(SYMBOL_DEPTH)) u_symbol_ram (
    .clk   (clk),
    .we    (cmd.sy_wr && sym_in_range(item.entry_index)),
    .waddr ({item.table_sel, item.entry_index}),
    .wdata (sy_wdata),
    .re    (cmd.chain_first || cmd.chain_next),
    .raddr ({op == OP_DIST, sym_addr_next}),
    .rdata (sy_rdata)
  );

  always_comb begin
    status.is_wr_lookup = item.opcode == OP_WR_LOOKUP;
    status.is_wr_symbol = item.opcode == OP_WR_SYMBOL;
    status.is_decode    = item.opcode == OP_LIT || item.opcode == OP_PAIR ||
                          item.opcode == OP_DIST;
    status.short_path   = lk_q.code_len <= SHORT_LEN_MAX;
    status.match        = (win[14:0] & sy_e.mask) == sy_e.code;
    status.steps_last   = step_cnt == STEP_W'(MAX_CHAIN_STEPS - 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.lk_rd) begin
      op   <= item.opcode;
      win  <= item.stream_bits;
      fail <= 1'b0;
    end
    if (cmd.take_short || cmd.chain_first) begin
      entry <= lk_q;
    end
    if (cmd.take_short) begin
      sym        <= lk_q.sym;
      len        <= lk_q.code_len;
      short_path <= 1'b1;
    end
    if (cmd.chain_first || cmd.chain_next) begin
      cur_sym <= sym_addr_next;
      cur_oob <= !sym_in_range(sym_addr_next);
    end
    if (cmd.chain_first) begin
      short_path <= 1'b0;
      step_cnt   <= '0;
    end
    if (cmd.chain_next) begin
      step_cnt <= step_cnt + STEP_W'(1);
    end
    if (cmd.take_chain) begin
      sym <= cur_sym;
      len <= sy_e.len;
    end
    if (cmd.set_fail) begin
      fail <= 1'b1;
    end
  end

  // result formatting from the settled symbol and length
  always_comb begin
    logic [4:0]  shift_n;
    logic [31:0] dist_base;
    logic [63:0] win_sh;
    logic [31:0] extra;
    logic [8:0]  pair_m1;
    shift_n   = sym[7:3] - 5'd1;
    dist_base = 32'({1'b0, 3'd0} + 4'd8 + {1'b0, sym[2:0]}) << shift_n;
    win_sh    = win >> len;
    extra     = win_sh[31:0] & ((32'd1 << shift_n) - 32'd1);
    pair_m1   = entry.pair_sym - 9'd1;
    result_next = '0;
    if (fail) begin
      result_next.error = 1'b1;
    end else begin
      result_next.first_symbol = sym;
      case (op)
        OP_LIT: begin
          result_next.symbol_count = 2'd1;
          result_next.bits_used    = 6'(len);
        end
        OP_PAIR: begin
          if (short_path && entry.pair_sym != 9'd0) begin
            result_next.second_symbol = pair_m1[7:0];
            result_next.symbol_count  = 2'd2;
            result_next.bits_used     = 6'(entry.pair_len);
          end else begin
            result_next.symbol_count = 2'd1;
            result_next.bits_used    = 6'(len);
          end
        end
        OP_DIST: begin
          if (sym >= DIST_SYM_LIMIT) begin
            result_next.bits_used = 6'(len);
            result_next.error     = 1'b1;
          end else if (sym < DIST_SYM_DIRECT) begin
            result_next.distance_value = 32'(sym);
            result_next.bits_used      = 6'(len);
          end else begin
            result_next.distance_value = dist_base + extra;
            result_next.bits_used      = 6'(len) + 6'(shift_n);
          end
        end
        default: begin
          result_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

endmodule

/* hw/rtl/hsd_ctrl.sv */
// ----------------------------------------------------------------------------
// hsd_ctrl: decode sequencer
// Steps one decode through lookup, chain walk and result formatting.
// ----------------------------------------------------------------------------
module hsd_ctrl import hsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  hsd_status_t status,
  output hsd_cmd_t    cmd,
  output logic        busy
);

  hsd_state_t state;
  hsd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.lk_wr = status.is_wr_lookup;
          cmd.sy_wr = status.is_wr_symbol;
          if (status.is_decode) begin
            cmd.lk_rd  = 1'b1;
            state_next = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        if (status.short_path) begin
          cmd.take_short = 1'b1;
          state_next     = ST_FINISH;
        end else begin
          cmd.chain_first = 1'b1;
          state_next      = ST_CHAIN;
        end
      end
      ST_CHAIN: begin
        if (status.match) begin
          cmd.take_chain = 1'b1;
          state_next     = ST_FINISH;
        end else if (status.steps_last) begin
          cmd.set_fail = 1'b1;
          state_next   = ST_FINISH;
        end else begin
          cmd.chain_next = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
